// ----- src/fibt_pkg.sv -----
package fibt_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_SET   = 2'd1,
        OP_POLL  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // slot status codes, values above ST_DONE are stored as given
    localparam logic [2:0] ST_EMPTY = 3'd0;
    localparam logic [2:0] ST_ALLOC = 3'd1;
    localparam logic [2:0] ST_SENT  = 3'd2;
    localparam logic [2:0] ST_RCVD  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [1:0] PO_NONE  = 2'd0;
    localparam logic [1:0] PO_OTHER = 2'd1;
    localparam logic [1:0] PO_FOUND = 2'd2;

    typedef struct packed {
        t_op         op;
        logic [3:0]  slot;
        logic [2:0]  new_status;
        logic        frame_present;
        logic        frame_is_ecat;
        logic [7:0]  frame_index;
        logic [15:0] frame_wkc;
        logic [15:0] frame_route;
    } t_in;

    typedef struct packed {
        logic [3:0]  alloc_slot;
        logic        alloc_failed;
        logic [1:0]  poll_outcome;
        logic [15:0] wkc_out;
        logic        frame_consumed;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PREAD,
        S_PDEC,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic take_req;
        logic scan_init;
        logic scan_step;
        logic alloc_finish;
        logic set_finish;
        logic poll_finish;
    } t_cmd;

    typedef struct packed {
        logic scan_busy;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

// ----- src/fibt_ctrl.sv -----
module fibt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  fibt_pkg::t_op  i_op,
    input  fibt_pkg::t_sts i_sts,
    output fibt_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);
    import fibt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_req = 1'b1;
                    unique case (i_op)
                        OP_ALLOC: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                        OP_POLL: n_state = S_PREAD;
                        OP_SET,
                        OP_NONE: n_state = S_FINISH;
                    endcase
                end
            end
            S_SCAN: begin
                // stop on an empty slot or after the whole ring was checked
                if (!i_sts.scan_busy || i_sts.scan_last) begin
                    if (i_sts.out_free) begin
                        o_cmd.alloc_finish = 1'b1;
                        n_state            = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_PREAD: n_state = S_PDEC;
            S_PDEC: begin
                if (i_sts.out_free) begin
                    o_cmd.poll_finish = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.set_finish = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- src/fibt_dp.sv -----
module fibt_dp #(
    parameter int NUM_SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fibt_pkg::t_in  i_in_data,
    input  fibt_pkg::t_cmd i_cmd,
    input  logic           i_out_stall,
    output fibt_pkg::t_sts o_sts,
    output logic           o_out_valid,
    output fibt_pkg::t_out o_out_data
);
    import fibt_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    t_in              r_req;
    logic [SW-1:0]    r_last;
    logic [SW-1:0]    r_idx;
    logic [SW-1:0]    r_cnt;
    logic [NUM_SLOTS-1:0] r_busy;
    logic [2:0]       r_st_mem  [NUM_SLOTS];
    logic [15:0]      r_wkc_mem [NUM_SLOTS];
    logic [2:0]       r_rd_st_a;
    logic [2:0]       r_rd_st_b;
    logic [15:0]      r_rd_wkc;
    t_out             r_out;
    logic             r_out_valid;

    logic [SW-1:0]    slot_idx;
    logic [SW-1:0]    fidx_idx;
    logic [SW-1:0]    n_first;
    logic             slot_in_range;
    logic             fidx_in_range;
    logic             slot_rcvd;
    logic             fidx_sent;
    logic             idx_match;
    logic             w_en;
    logic             wk_en;
    logic [SW-1:0]    w_addr;
    logic [2:0]       w_st;
    t_out             n_out;

    assign slot_idx      = SW'(r_req.slot);
    assign fidx_idx      = SW'(r_req.frame_index);
    assign slot_in_range = (32'(r_req.slot) < NUM_SLOTS);
    assign fidx_in_range = (32'(r_req.frame_index) < NUM_SLOTS);
    assign n_first       = (r_last == SW'(NUM_SLOTS - 1)) ? '0 : r_last + 1'b1;

    // a slot whose busy flag is clear reads as empty
    assign slot_rcvd = slot_in_range && r_busy[slot_idx] && (r_rd_st_a == ST_RCVD);
    assign fidx_sent = fidx_in_range && r_busy[fidx_idx] && (r_rd_st_b == ST_SENT);
    assign idx_match = ({4'h0, r_req.slot} == r_req.frame_index);

    always_comb begin
        w_en   = 1'b0;
        wk_en  = 1'b0;
        w_addr = slot_idx;
        w_st   = ST_EMPTY;
        n_out  = '0;
        if (i_cmd.alloc_finish) begin
            if (!r_busy[r_idx]) begin
                w_en             = 1'b1;
                w_addr           = r_idx;
                w_st             = ST_ALLOC;
                n_out.alloc_slot = 4'(r_idx);
            end else begin
                n_out.alloc_failed = 1'b1;
            end
        end
        if (i_cmd.set_finish) begin
            if (r_req.op == OP_SET && slot_in_range) begin
                w_en = 1'b1;
                w_st = r_req.new_status;
            end
        end
        if (i_cmd.poll_finish) begin
            priority if (slot_rcvd) begin
                n_out.poll_outcome = PO_FOUND;
                n_out.wkc_out      = r_rd_wkc;
                w_en               = 1'b1;
                w_st               = ST_DONE;
            end else if (r_req.frame_present) begin
                n_out.frame_consumed = 1'b1;
                n_out.poll_outcome   = PO_OTHER;
                if (r_req.frame_is_ecat) begin
                    priority if (idx_match) begin
                        n_out.poll_outcome = PO_FOUND;
                        n_out.wkc_out      = r_req.frame_wkc;
                        if (slot_in_range) begin
                            w_en  = 1'b1;
                            wk_en = 1'b1;
                            w_st  = ST_DONE;
                        end
                    end else if (fidx_sent) begin
                        // park the frame in its own slot
                        w_en   = 1'b1;
                        wk_en  = 1'b1;
                        w_addr = fidx_idx;
                        w_st   = ST_RCVD;
                    end else begin
                        // no slot waits for it, frame dropped
                        n_out.poll_outcome = PO_OTHER;
                    end
                end
            end else begin
                // no frame waiting
                n_out.poll_outcome = PO_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_req <= i_in_data;
        end
        if (i_cmd.scan_init) begin
            r_idx <= n_first;
            r_cnt <= '0;
        end else if (i_cmd.scan_step) begin
            r_idx <= (r_idx == SW'(NUM_SLOTS - 1)) ? '0 : r_idx + 1'b1;
            r_cnt <= r_cnt + 1'b1;
        end
        if (w_en) begin
            r_st_mem[w_addr] <= w_st;
        end
        if (wk_en) begin
            r_wkc_mem[w_addr] <= r_req.frame_wkc;
        end
        r_rd_st_a <= r_st_mem[slot_idx];
        r_rd_st_b <= r_st_mem[fidx_idx];
        r_rd_wkc  <= r_wkc_mem[slot_idx];
        if (i_cmd.alloc_finish || i_cmd.set_finish || i_cmd.poll_finish) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_busy[w_addr] <= (w_st != ST_EMPTY);
            end
            if (i_cmd.alloc_finish && !r_busy[r_idx]) begin
                r_last <= r_idx;
            end
            if (i_cmd.alloc_finish || i_cmd.set_finish || i_cmd.poll_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.scan_busy = r_busy[r_idx];
    assign o_sts.scan_last = (r_cnt == SW'(NUM_SLOTS - 1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

// ----- src/frame_index_buffer_tracker.sv -----
// set-status and unknown op pass through the finish state, poll reads the slot memory and then decodes,
// allocate scans ahead, skipping up to NUM_SLOTS-1 occupied slots; each finish waits while a stalled result is held;
// the round-robin scan checks one slot busy flag per cycle
// a new request is taken in the cycle after its result is registered, also while it waits
// synchronous active-low reset marks every slot empty through its busy flag, clears the
// last granted slot and the output valid flag; no clearing pass, requests taken right away
module frame_index_buffer_tracker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  fibt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fibt_pkg::t_out o_out_data
);
    import fibt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    fibt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    fibt_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- src/fibt_chk.sv -----
module fibt_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input fibt_pkg::t_out o_out_data
);
    import fibt_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    // a new result only comes out of a busy cycle
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without request in progress");

    // counter is shown only on a found poll
    a_wkc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.poll_outcome != PO_FOUND) |-> (o_out_data.wkc_out == 16'h0))
        else $error("working counter on non-found result");

endmodule

bind frame_index_buffer_tracker fibt_chk u_fibt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
